// ===== rtl/ofbp_pkg.sv =====
// Shared types and constants for the fisheye back-projection unit.
`default_nettype none
package ofbp_pkg;

  // Number of polynomial coefficients.
  localparam int unsigned NumCoeff = 5;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegAffine = 3'd0;
  localparam logic [2:0] RegCenter = 3'd1;
  localparam logic [2:0] RegCoeff0 = 3'd2;
  localparam logic [2:0] RegCoeff4 = 3'd6;

  // Reset value of the affine matrix: identity in Q2.14.
  localparam logic [63:0] AffineReset = 64'h4000_0000_0000_4000;

  // Pipeline depths.
  localparam int unsigned SqrtSteps = 32;
  localparam int unsigned DivSteps  = 33;
  localparam int unsigned HornerSt  = 9;

  typedef struct packed {
    logic [15:0] pixel_x;
    logic [15:0] pixel_y;
    logic [23:0] depth;
  } in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [23:0]        point_z;
    logic               divide_by_zero;
    logic               saturated;
  } res_t;

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic signed [33:0] u;
    logic signed [33:0] v;
    logic [31:0]        rho;
    logic [23:0]        depth;
  } mid_t;

  // Configuration used by the front part.
  typedef struct packed {
    logic [63:0] affine;
    logic [31:0] center;
  } front_cfg_t;

endpackage
`default_nettype wire

// ===== rtl/ofbp_front.sv =====
// Front part: centering, affine transform and pipelined radius square root.
`default_nettype none
module ofbp_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ofbp_pkg::front_cfg_t cfg_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ofbp_pkg::in_t       in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ofbp_pkg::mid_t           out_item_o
);
  import ofbp_pkg::*;

  typedef struct packed {
    logic signed [33:0] u;
    logic signed [33:0] v;
    logic [23:0]        depth;
    logic [63:0]        rem;
    logic [31:0]        root;
  } sq_t;

  logic en;

  // Early stages.
  logic        v0_q, v1_q, v2_q, v3_q, v4_q, v5_q;
  in_t         s0_q;
  logic signed [16:0] dx_q, dy_q;
  logic [23:0] d1_q, d2_q, d3_q, d4_q, d5_q;
  logic signed [32:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [33:0] u3_q, v3s_q, u4_q, v4_q2, u5_q, v5s_q;
  logic [31:0] ua_q, va_q;
  logic [63:0] ua2_q, va2_q;
  sq_t         sq_q [SqrtSteps+1];
  logic        sv_q [SqrtSteps+1];
  sq_t         sq_d [SqrtSteps+1];

  // The whole pipeline advances unless the last item is stuck.
  assign en          = ~sv_q[SqrtSteps] | out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = sv_q[SqrtSteps];
  assign out_item_o  = '{u: sq_q[SqrtSteps].u, v: sq_q[SqrtSteps].v,
                         rho: sq_q[SqrtSteps].root, depth: sq_q[SqrtSteps].depth};

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      for (int k = 0; k <= SqrtSteps; k++) sv_q[k] <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      sv_q[0] <= v5_q;
      for (int k = 1; k <= SqrtSteps; k++) sv_q[k] <= sv_q[k-1];
    end
  end

  // Centering, products, sums, magnitudes and squares.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q  <= in_item_i;
      dx_q  <= $signed({1'b0, s0_q.pixel_x}) - $signed({1'b0, cfg_i.center[15:0]});
      dy_q  <= $signed({1'b0, s0_q.pixel_y}) - $signed({1'b0, cfg_i.center[31:16]});
      d1_q  <= s0_q.depth;
      p00_q <= $signed(cfg_i.affine[15:0])  * dx_q;
      p01_q <= $signed(cfg_i.affine[31:16]) * dy_q;
      p10_q <= $signed(cfg_i.affine[47:32]) * dx_q;
      p11_q <= $signed(cfg_i.affine[63:48]) * dy_q;
      d2_q  <= d1_q;
      u3_q  <= 34'(p00_q) + 34'(p01_q);
      v3s_q <= 34'(p10_q) + 34'(p11_q);
      d3_q  <= d2_q;
      ua_q  <= 32'(((u3_q[33]) ? -u3_q : u3_q) >>> 2);
      va_q  <= 32'(((v3s_q[33]) ? -v3s_q : v3s_q) >>> 2);
      u4_q  <= u3_q;
      v4_q2 <= v3s_q;
      d4_q  <= d3_q;
      ua2_q <= ua_q * ua_q;
      va2_q <= va_q * va_q;
      u5_q  <= u4_q;
      v5s_q <= v4_q2;
      d5_q  <= d4_q;
      sq_q[0] <= sq_d[0];
      for (int k = 1; k <= SqrtSteps; k++) sq_q[k] <= sq_d[k];
    end
  end

  // Square root load stage.
  always_comb begin
    sq_d[0].u     = u5_q;
    sq_d[0].v     = v5s_q;
    sq_d[0].depth = d5_q;
    sq_d[0].rem   = ua2_q + va2_q;
    sq_d[0].root  = '0;
  end

  // One root bit per stage, most significant first.
  for (genvar j = 1; j <= SqrtSteps; j++) begin : g_sqrt
    localparam int unsigned Bit = SqrtSteps - j;
    logic [65:0] trial;
    always_comb begin
      trial = ({34'd0, sq_q[j-1].root} << (Bit + 1)) | (66'd1 << (2 * Bit));
      sq_d[j] = sq_q[j-1];
      if ({2'b00, sq_q[j-1].rem} >= trial) begin
        sq_d[j].rem  = sq_q[j-1].rem - trial[63:0];
        sq_d[j].root = sq_q[j-1].root | (32'd1 << Bit);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ofbp_queue.sv =====
// Two-entry queue between the front and back parts.
`default_nettype none
module ofbp_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ofbp_pkg::mid_t in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ofbp_pkg::mid_t      out_item_o
);
  import ofbp_pkg::*;

  mid_t       mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wp_q, rp_q;
  logic       wr, rd;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = mem_q[rp_q];
  assign wr = in_valid_i & in_ready_o;
  assign rd = out_valid_o & out_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (wr && !rd) cnt_d = cnt_q + 2'd1;
    else if (rd && !wr) cnt_d = cnt_q - 2'd1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_item_i;
  end

endmodule
`default_nettype wire

// ===== rtl/ofbp_back.sv =====
// Back part: Horner polynomial, pipelined dividers, saturation and result queue.
`default_nettype none
module ofbp_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic signed [31:0]  coeff_i [ofbp_pkg::NumCoeff],
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ofbp_pkg::mid_t      in_item_i,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output ofbp_pkg::res_t           result_o
);
  import ofbp_pkg::*;

  typedef struct packed {
    logic signed [33:0] u;
    logic signed [33:0] v;
    logic [23:0]        depth;
    logic [31:0]        rho;
    logic signed [31:0] p;
    logic signed [64:0] prod;
  } hc_t;

  typedef struct packed {
    logic signed [57:0] nx;
    logic signed [57:0] ny;
    logic signed [33:0] den;
    logic               dz;
    logic [23:0]        depth;
  } pn_t;

  typedef struct packed {
    logic [57:0] rx;
    logic [57:0] ry;
    logic [32:0] qx;
    logic [32:0] qy;
    logic [33:0] den;
    logic        negx;
    logic        negy;
    logic        ovfx;
    logic        ovfy;
    logic        dz;
    logic [23:0] depth;
  } dv_t;

  logic en, last_v, fifo_ready;

  hc_t  h_q [HornerSt];
  hc_t  h_d [HornerSt];
  logic hv_q [HornerSt];
  pn_t  pn_q;
  logic pnv_q;
  dv_t  dv_q [DivSteps+1];
  dv_t  dv_d [DivSteps+1];
  logic dvv_q [DivSteps+1];

  assign last_v     = dvv_q[DivSteps];
  assign en         = ~last_v | fifo_ready;
  assign in_ready_o = en;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HornerSt; k++) hv_q[k] <= 1'b0;
      pnv_q <= 1'b0;
      for (int k = 0; k <= DivSteps; k++) dvv_q[k] <= 1'b0;
    end else if (en) begin
      hv_q[0] <= in_valid_i;
      for (int k = 1; k < HornerSt; k++) hv_q[k] <= hv_q[k-1];
      pnv_q    <= hv_q[HornerSt-1];
      dvv_q[0] <= pnv_q;
      for (int k = 1; k <= DivSteps; k++) dvv_q[k] <= dvv_q[k-1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < HornerSt; k++) h_q[k] <= h_d[k];
      pn_q.nx    <= 58'(h_q[HornerSt-1].u * $signed({1'b0, h_q[HornerSt-1].depth}));
      pn_q.ny    <= 58'(h_q[HornerSt-1].v * $signed({1'b0, h_q[HornerSt-1].depth}));
      pn_q.den   <= $signed({h_q[HornerSt-1].p, 2'b00});
      pn_q.dz    <= (h_q[HornerSt-1].p == 32'sd0);
      pn_q.depth <= h_q[HornerSt-1].depth;
      for (int k = 0; k <= DivSteps; k++) dv_q[k] <= dv_d[k];
    end
  end

  // Horner load stage: start from the quartic coefficient.
  always_comb begin
    h_d[0].u     = in_item_i.u;
    h_d[0].v     = in_item_i.v;
    h_d[0].depth = in_item_i.depth;
    h_d[0].rho   = in_item_i.rho;
    h_d[0].p     = coeff_i[NumCoeff-1];
    h_d[0].prod  = '0;
  end

  // Each Horner step: a multiply stage and then a scale, add and clip stage.
  for (genvar j = 0; j < NumCoeff - 1; j++) begin : g_horner
    localparam int unsigned Ck = NumCoeff - 2 - j;
    logic [64:0]        pmag;
    logic [36:0]        tmag;
    logic signed [38:0] tval, sum;
    always_comb begin
      h_d[2*j+1]      = h_q[2*j];
      h_d[2*j+1].prod = h_q[2*j].p * $signed({1'b0, h_q[2*j].rho});
    end
    always_comb begin
      pmag = h_q[2*j+1].prod[64] ? 65'(-h_q[2*j+1].prod) : h_q[2*j+1].prod;
      tmag = pmag[64:28];
      tval = h_q[2*j+1].prod[64] ? -$signed({2'b00, tmag}) : $signed({2'b00, tmag});
      sum  = 39'(coeff_i[Ck]) + tval;
      h_d[2*j+2] = h_q[2*j+1];
      if (sum > 39'sd2147483647) h_d[2*j+2].p = 32'sh7fff_ffff;
      else if (sum < -39'sd2147483648) h_d[2*j+2].p = 32'sh8000_0000;
      else h_d[2*j+2].p = sum[31:0];
    end
  end

  // Divider load: magnitudes, quotient signs and the quotient range check.
  logic [57:0] mx, my;
  logic [33:0] dm;
  always_comb begin
    mx = pn_q.nx[57] ? 58'(-pn_q.nx) : pn_q.nx;
    my = pn_q.ny[57] ? 58'(-pn_q.ny) : pn_q.ny;
    dm = pn_q.den[33] ? 34'(-pn_q.den) : pn_q.den;
    dv_d[0].rx    = mx;
    dv_d[0].ry    = my;
    dv_d[0].qx    = '0;
    dv_d[0].qy    = '0;
    dv_d[0].den   = dm;
    dv_d[0].negx  = pn_q.nx[57] ^ pn_q.den[33];
    dv_d[0].negy  = pn_q.ny[57] ^ pn_q.den[33];
    dv_d[0].ovfx  = ({9'd0, mx} >= ({33'd0, dm} << DivSteps));
    dv_d[0].ovfy  = ({9'd0, my} >= ({33'd0, dm} << DivSteps));
    dv_d[0].dz    = pn_q.dz;
    dv_d[0].depth = pn_q.depth;
  end

  // Restoring division, one quotient bit per stage for both coordinates.
  for (genvar j = 1; j <= DivSteps; j++) begin : g_div
    localparam int unsigned Bit = DivSteps - j;
    logic [66:0] dsh;
    always_comb begin
      dsh = {33'd0, dv_q[j-1].den} << Bit;
      dv_d[j] = dv_q[j-1];
      if ({9'd0, dv_q[j-1].rx} >= dsh) begin
        dv_d[j].rx = dv_q[j-1].rx - dsh[57:0];
        dv_d[j].qx = dv_q[j-1].qx | (33'd1 << Bit);
      end
      if ({9'd0, dv_q[j-1].ry} >= dsh) begin
        dv_d[j].ry = dv_q[j-1].ry - dsh[57:0];
        dv_d[j].qy = dv_q[j-1].qy | (33'd1 << Bit);
      end
    end
  end

  // Sign, saturation and the zero-polynomial case.
  res_t res;
  logic sx, sy;
  always_comb begin
    sx = 1'b0;
    sy = 1'b0;
    res.point_z = dv_q[DivSteps].depth;
    res.divide_by_zero = dv_q[DivSteps].dz;
    if (dv_q[DivSteps].negx) begin
      if (dv_q[DivSteps].ovfx || dv_q[DivSteps].qx > 33'h1_0000_0000 >> 1) begin
        sx = 1'b1;
        res.point_x = 32'sh8000_0000;
      end else res.point_x = 32'(-dv_q[DivSteps].qx);
    end else begin
      if (dv_q[DivSteps].ovfx || dv_q[DivSteps].qx > 33'h0_7fff_ffff) begin
        sx = 1'b1;
        res.point_x = 32'sh7fff_ffff;
      end else res.point_x = dv_q[DivSteps].qx[31:0];
    end
    if (dv_q[DivSteps].negy) begin
      if (dv_q[DivSteps].ovfy || dv_q[DivSteps].qy > 33'h1_0000_0000 >> 1) begin
        sy = 1'b1;
        res.point_y = 32'sh8000_0000;
      end else res.point_y = 32'(-dv_q[DivSteps].qy);
    end else begin
      if (dv_q[DivSteps].ovfy || dv_q[DivSteps].qy > 33'h0_7fff_ffff) begin
        sy = 1'b1;
        res.point_y = 32'sh7fff_ffff;
      end else res.point_y = dv_q[DivSteps].qy[31:0];
    end
    res.saturated = sx | sy;
    if (dv_q[DivSteps].dz) begin
      res.point_x   = '0;
      res.point_y   = '0;
      res.saturated = 1'b0;
    end
  end

  // Two-entry result queue.
  res_t       rq_q [2];
  logic [1:0] rc_q;
  logic       rw_q, rr_q, rwr, rrd;

  assign fifo_ready = (rc_q != 2'd2);
  assign empty_o    = (rc_q == 2'd0);
  assign result_o   = rq_q[rr_q];
  assign rwr = last_v & fifo_ready;
  assign rrd = pop_i & ~empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= 2'd0;
      rw_q <= 1'b0;
      rr_q <= 1'b0;
    end else begin
      if (rwr && !rrd) rc_q <= rc_q + 2'd1;
      else if (rrd && !rwr) rc_q <= rc_q - 2'd1;
      if (rwr) rw_q <= ~rw_q;
      if (rrd) rr_q <= ~rr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rwr) rq_q[rw_q] <= res;
  end

endmodule
`default_nettype wire

// ===== rtl/omni_fisheye_back_projection_unit.sv =====
// Top level of the fisheye back-projection unit: registers and part wiring.
`default_nettype none
// Maps a distorted fisheye pixel and a depth to a 3D point. The unit is fully
// pipelined and accepts one item per clock cycle while full is low; each item
// passes the six-stage centering and affine front, the 32-stage radius square
// root, the four two-stage Horner steps and the 33-stage quotient dividers, is
// then written into the result queue and can be popped from the next edge on.
// Two-entry queues sit between the front and back parts and at the output, so
// either side can stall without losing items.
// Write configuration only while idle.
module omni_fisheye_back_projection_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [2:0]      cfg_idx_i,
  input  wire logic [63:0]     cfg_data_i,
  input  wire logic            push,
  output logic                 full,
  input  wire ofbp_pkg::in_t   in_item_i,
  output logic                 empty,
  input  wire logic            pop,
  output ofbp_pkg::res_t       result_o
);
  import ofbp_pkg::*;

  logic [63:0]        affine_q;
  logic [31:0]        center_q;
  logic signed [31:0] coeff_q [NumCoeff];
  front_cfg_t         fcfg;
  logic               f_ready, f_valid, q_ready, q_valid, b_ready;
  mid_t               f_item, q_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      affine_q <= AffineReset;
      center_q <= '0;
      for (int k = 0; k < NumCoeff; k++) coeff_q[k] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == RegAffine) affine_q <= cfg_data_i;
      else if (cfg_idx_i == RegCenter) center_q <= cfg_data_i[31:0];
      else if (cfg_idx_i >= RegCoeff0 && cfg_idx_i <= RegCoeff4) begin
        coeff_q[3'(cfg_idx_i - RegCoeff0)] <= cfg_data_i[31:0];
      end
    end
  end

  assign fcfg = '{affine: affine_q, center: center_q};
  assign full = ~f_ready;

  ofbp_front u_front (
    .clk_i, .rst_ni, .cfg_i(fcfg),
    .in_valid_i(push), .in_ready_o(f_ready), .in_item_i,
    .out_valid_o(f_valid), .out_ready_i(q_ready), .out_item_o(f_item)
  );

  ofbp_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(q_ready), .in_item_i(f_item),
    .out_valid_o(q_valid), .out_ready_i(b_ready), .out_item_o(q_item)
  );

  ofbp_back u_back (
    .clk_i, .rst_ni, .coeff_i(coeff_q),
    .in_valid_i(q_valid), .in_ready_o(b_ready), .in_item_i(q_item),
    .empty_o(empty), .pop_i(pop), .result_o
  );

endmodule
`default_nettype wire
